### sv/pmct_pkg.sv
`timescale 1ns / 1ps
// pmct_pkg: shared types, constants and helpers for the ps/2 mouse cursor tracker
// no dependencies

package pmct_pkg;

    localparam int CoordBits = 13;
    localparam int SizeBits  = 14;
    localparam int DeltaBits = 10;
    localparam int TdataInW  = 8;
    localparam int TuserInW  = 3;
    localparam int TdataOutW = 32;
    localparam int CfgIdxW   = 1;

    localparam logic [SizeBits-1:0] CoordLimit = SizeBits'(1 << CoordBits);

    // header bit positions
    localparam int HdrLeft    = 0;
    localparam int HdrRight   = 1;
    localparam int HdrMiddle  = 2;
    localparam int HdrSync    = 3;
    localparam int HdrXSign   = 4;
    localparam int HdrYSign   = 5;

    typedef enum logic [1:0] {
        OpRxByte     = 2'd0,
        OpClearFlags = 2'd1,
        OpCentre     = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        PhHeader = 2'd0,
        PhXByte  = 2'd1,
        PhYByte  = 2'd2
    } t_phase;

    localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgScreenHeight = 1'd1;

    // zero reads as one, anything past the coordinate range is limited to it
    function automatic logic [SizeBits-1:0] eff_size(input logic [SizeBits-1:0] s);
        logic [SizeBits-1:0] r;
        r = s;
        if (s == '0) r = SizeBits'(1);
        if (s > CoordLimit) r = CoordLimit;
        return r;
    endfunction

endpackage

### sv/ps2_mouse_packet_cursor_tracker.sv
`timescale 1ns / 1ps
// ps2_mouse_packet_cursor_tracker: 3-byte ps/2 mouse packet decoder with clamped cursor
// an accepted word goes through the input register and then the result register; stalls can hold it
// one word per cycle unless stalled; combinational update between input and result register
// reset: synchronous active-low i_rst_n clears cursor, buttons, flags, phase, screen 1024 x 768
// depends on pmct_pkg and pmct_clamp

module ps2_mouse_packet_cursor_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pmct_pkg::TdataInW-1:0]     s_axis_tdata,  // rx_byte[7:0]
    input  logic [pmct_pkg::TuserInW-1:0]     s_axis_tuser,  // opcode[1:0], from_aux[2]
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // cursor_x[12:0], cursor_y[25:13], left_down[26], right_down[27], middle_down[28],
    // left_pressed_flag[29], left_released_flag[30], zero[31]
    output logic [pmct_pkg::TdataOutW-1:0]    m_axis_tdata,
    output logic [0:0]                        m_axis_tuser,  // packet_done[0]
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pmct_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [pmct_pkg::SizeBits-1:0]     i_cfg_data
);
    import pmct_pkg::*;

    // screen size registers
    logic [SizeBits-1:0]  r_width, r_height;

    // input register
    logic                 r_in_valid;
    logic [1:0]           r_in_opcode;
    logic [7:0]           r_in_byte;
    logic                 r_in_aux;

    // decoder state
    t_phase               r_phase, n_phase;
    logic [7:0]           r_header, n_header;
    logic [7:0]           r_xbyte, n_xbyte;
    logic [CoordBits-1:0] r_pos_x, n_pos_x;
    logic [CoordBits-1:0] r_pos_y, n_pos_y;
    logic [2:0]           r_buttons, n_buttons;
    logic [1:0]           r_flags, n_flags;   // bit0 pressed, bit1 released
    logic                 n_done;

    // result register
    logic                 r_out_valid;
    logic [TdataOutW-2:0] r_out_data;
    logic                 r_out_done;

    logic                 advance;
    logic                 fire;
    logic                 is_packet_end;

    logic signed [DeltaBits-1:0] dx, dy_neg;
    logic [CoordBits-1:0] move_x, move_y;
    logic [SizeBits-1:0]  eff_w, eff_h;

    // result stage moves on when empty or being drained
    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_data};
    assign m_axis_tuser  = r_out_done;

    // x from header sign and stored byte; y negated since screen rows grow downward
    assign dx     = DeltaBits'($signed({r_header[HdrXSign], r_xbyte}));
    assign dy_neg = -DeltaBits'($signed({r_header[HdrYSign], r_in_byte}));

    assign eff_w  = eff_size(r_width);
    assign eff_h  = eff_size(r_height);

    pmct_clamp u_clamp_x (
        .i_pos   (r_pos_x),
        .i_delta (dx),
        .i_size  (r_width),
        .o_pos   (move_x)
    );

    pmct_clamp u_clamp_y (
        .i_pos   (r_pos_y),
        .i_delta (dy_neg),
        .i_size  (r_height),
        .o_pos   (move_y)
    );

    // third aux byte of a packet
    assign is_packet_end = fire && (r_in_opcode == OpRxByte) && r_in_aux
                           && (r_phase == PhYByte);

    // packet phase next state
    always_comb begin
        n_phase = r_phase;
        if (fire && (r_in_opcode == OpRxByte) && r_in_aux) begin
            case (r_phase)
                PhXByte: n_phase = PhYByte;
                PhYByte: n_phase = PhHeader;
                default: begin
                    // only a byte with the sync bit starts a packet
                    n_phase = r_in_byte[HdrSync] ? PhXByte : PhHeader;
                end
            endcase
        end
    end

    // datapath updates
    always_comb begin
        n_header  = r_header;
        n_xbyte   = r_xbyte;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_buttons = r_buttons;
        n_flags   = r_flags;
        n_done    = 1'b0;
        if (fire) begin
            case (r_in_opcode)
                OpRxByte: begin
                    if (r_in_aux) begin
                        case (r_phase)
                            PhXByte: n_xbyte = r_in_byte;
                            PhYByte: begin
                                n_pos_x    = move_x;
                                n_pos_y    = move_y;
                                // sticky edges of the left button
                                n_flags[0] = r_flags[0]
                                             | (r_header[HdrLeft] & ~r_buttons[0]);
                                n_flags[1] = r_flags[1]
                                             | (~r_header[HdrLeft] & r_buttons[0]);
                                n_buttons  = {r_header[HdrMiddle], r_header[HdrRight],
                                              r_header[HdrLeft]};
                                n_done     = 1'b1;
                            end
                            default: n_header = r_in_byte;
                        endcase
                    end
                end
                OpClearFlags: n_flags = '0;
                OpCentre: begin
                    n_pos_x = CoordBits'(eff_w >> 1);
                    n_pos_y = CoordBits'(eff_h >> 1);
                end
                default: ;
            endcase
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SizeBits'(1024);
            r_height <= SizeBits'(768);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgScreenWidth:  r_width  <= i_cfg_data;
                CfgScreenHeight: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_opcode <= s_axis_tuser[1:0];
            r_in_aux    <= s_axis_tuser[2];
            r_in_byte   <= s_axis_tdata;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PhHeader;
            r_header  <= '0;
            r_xbyte   <= '0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_buttons <= '0;
            r_flags   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_header  <= n_header;
            r_xbyte   <= n_xbyte;
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_buttons <= n_buttons;
            r_flags   <= n_flags;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {n_flags[1], n_flags[0], n_buttons[2], n_buttons[1],
                           n_buttons[0], n_pos_y, n_pos_x};
            r_out_done <= n_done;
        end
    end

`ifndef SYNTHESIS
    // a completed packet always leaves the decoder waiting for a header
    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_done |-> r_phase == PhHeader)
        else $error("packet_done shown while packet phase not at header");

    // the third byte of a packet always shows packet_done in the result register
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_packet_end |=> r_out_valid && r_out_done)
        else $error("packet end did not produce packet_done");

    // a stalled input register keeps its word
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte)
                                   && $stable(r_in_opcode) && $stable(r_in_aux))
        else $error("input register changed while stalled");

    // the block takes input whenever the result register is free
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input not ready with empty result register");
`endif

endmodule

### sv/pmct_clamp.sv
`timescale 1ns / 1ps
// pmct_clamp: moves one coordinate by a signed delta and clamps it to the screen
// depends on pmct_pkg

module pmct_clamp (
    input  logic [pmct_pkg::CoordBits-1:0]        i_pos,
    input  logic signed [pmct_pkg::DeltaBits-1:0] i_delta,
    input  logic [pmct_pkg::SizeBits-1:0]         i_size,
    output logic [pmct_pkg::CoordBits-1:0]        o_pos
);
    import pmct_pkg::*;

    localparam int SumW = CoordBits + 2;

    logic [SizeBits-1:0]    eff;
    logic [CoordBits-1:0]   max_pos;
    logic signed [SumW-1:0] sum;

    always_comb begin
        eff     = eff_size(i_size);
        max_pos = CoordBits'(eff - SizeBits'(1));
        sum     = $signed({2'b00, i_pos}) + SumW'(i_delta);
        if (sum < 0) begin
            o_pos = '0;
        end else if (sum > $signed({2'b00, max_pos})) begin
            o_pos = max_pos;
        end else begin
            o_pos = sum[CoordBits-1:0];
        end
    end

endmodule
